### rtl/core/tfp_pkg.sv
// Package for the pose to transform pipeline: fixed-point constants,
// pipeline stage types and rounding/multiply helper functions.
// No dependencies.
`default_nettype none
package tfp_pkg;

  localparam int NumAng   = 3;
  localparam int NumStage = 11;

  localparam logic [30:0] TurnScale = 31'd683565276;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  // reciprocal constants for exact floor division of 30-bit values
  localparam logic [63:0] One64 = 64'd1;
  localparam int K6  = 33;
  localparam int K24 = 35;
  localparam int K120 = 37;
  localparam int K720 = 40;
  localparam int K5040 = 43;
  localparam int K40320 = 46;
  localparam int K362880 = 49;
  localparam int K3628800 = 52;
  localparam logic [63:0] M6w  = ((One64 << K6) + 64'd5) / 64'd6;
  localparam logic [63:0] M24w = ((One64 << K24) + 64'd23) / 64'd24;
  localparam logic [63:0] M120w = ((One64 << K120) + 64'd119) / 64'd120;
  localparam logic [63:0] M720w = ((One64 << K720) + 64'd719) / 64'd720;
  localparam logic [63:0] M5040w = ((One64 << K5040) + 64'd5039) / 64'd5040;
  localparam logic [63:0] M40320w = ((One64 << K40320) + 64'd40319) / 64'd40320;
  localparam logic [63:0] M362880w = ((One64 << K362880) + 64'd362879) / 64'd362880;
  localparam logic [63:0] M3628800w = ((One64 << K3628800) + 64'd3628799) / 64'd3628800;
  localparam logic [31:0] M6 = M6w[31:0];
  localparam logic [31:0] M24 = M24w[31:0];
  localparam logic [31:0] M120 = M120w[31:0];
  localparam logic [31:0] M720 = M720w[31:0];
  localparam logic [31:0] M5040 = M5040w[31:0];
  localparam logic [31:0] M40320 = M40320w[31:0];
  localparam logic [31:0] M362880 = M362880w[31:0];
  localparam logic [31:0] M3628800 = M3628800w[31:0];

  typedef struct packed {
    logic [1:0]  q;
    logic        swap;
    logic [29:0] x1;
    logic [29:0] x2;
    logic [29:0] x3;
    logic [29:0] x4;
    logic [29:0] x5;
    logic [29:0] x6;
    logic [29:0] x7;
    logic [29:0] x8;
    logic [29:0] x9;
    logic [29:0] x10;
  } pw_t;

  typedef struct packed {
    logic [1:0]  q;
    logic        swap;
    logic [29:0] x1;
    logic [29:0] t2;
    logic [29:0] t3;
    logic [29:0] t4;
    logic [29:0] t5;
    logic [29:0] t6;
    logic [29:0] t7;
    logic [29:0] t8;
    logic [29:0] t9;
    logic [29:0] t10;
  } term_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } sc_t;

  function automatic logic [29:0] umul_q30(input logic [29:0] a, input logic [29:0] b);
    logic [60:0] p;
    p = {31'd0, a} * {31'd0, b} + (61'd1 << 29);
    return p[59:30];
  endfunction

  function automatic logic [29:0] divc(input logic [29:0] v, input logic [31:0] m,
                                       input int k);
    logic [61:0] p;
    logic [61:0] s;
    p = {32'd0, v} * {30'd0, m};
    s = p >> k;
    return s[29:0];
  endfunction

  function automatic logic signed [31:0] smul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  function automatic logic [23:0] to_q22(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd128) >>> 8;
    if (t > 34'sd8388607) return 24'h7FFFFF;
    if (t < -34'sd8388608) return 24'h800000;
    return t[23:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/transform_from_pose_unit.sv
// Pose (x, y, z, w, p, r) to top three rows of the homogeneous transform.
// Uses tfp_pkg for constants and arithmetic helpers.
//
// Usage:
//   Input beats on in_t*: three Q16.16 positions and three Q3.20 angles.
//   Output beats on out_t*: nine Q1.22 rotation entries (R = Rz*Ry*Rx)
//   and the three positions passed through.
//   Every input beat gives exactly one output beat, in order.
//   Throughput: one beat per cycle while out_tready is high; eleven register stages (phase, angle
//   scaling, four power stages, reciprocal divide, series sum, two matrix
//   multiply stages, output rounding) each hold one beat.
//   Stall: each stage holds while its successor is full and stalled, so
//   bubbles close up and the pipe keeps accepting until all stages fill.
//   Nothing is lost or repeated.
//   Reset: synchronous rst_n clears all stage valid bits; no beat is in
//   flight after reset.
`default_nettype none
module transform_from_pose_unit
  import tfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // x_position, y_position, z_position, angle_w, angle_p, angle_r
  input  wire logic [167:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // trans_x, trans_y, trans_z
  output logic [311:0]      out_tdata
);

  logic [NumStage-1:0] vld_r;
  logic [NumStage:0]   rdy;

  always_comb begin
    rdy[NumStage] = out_tready;
    for (int i = NumStage - 1; i >= 0; i--) begin
      rdy[i] = ~vld_r[i] | rdy[i+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NumStage-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NumStage; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // translation travels alongside
  logic [95:0] tr_r [NumStage];

  always_ff @(posedge clk) begin
    if (rdy[0]) tr_r[0] <= in_tdata[95:0];
    for (int i = 1; i < NumStage; i++) begin
      if (rdy[i]) tr_r[i] <= tr_r[i-1];
    end
  end

  // stage 0: phase as fraction of a turn
  logic [31:0] ph_r [NumAng];
  logic [31:0] ph_nxt [NumAng];

  always_comb begin
    logic signed [23:0] ang;
    logic signed [55:0] prod;
    for (int a = 0; a < NumAng; a++) begin
      ang  = in_tdata[96 + 24*a +: 24];
      prod = 56'(ang) * $signed({25'd0, TurnScale}) + 56'sd524288;
      ph_nxt[a] = prod[51:20];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) ph_r <= ph_nxt;
  end

  // stages 1..5: octant fold and powers of x
  pw_t pw_r [1:5][NumAng];
  pw_t pw1_nxt [NumAng];
  pw_t pw_nxt [2:5][NumAng];

  always_comb begin
    logic [29:0] f;
    logic [30:0] g;
    logic [61:0] p;
    for (int a = 0; a < NumAng; a++) begin
      f = ph_r[a][29:0];
      pw1_nxt[a]      = '0;
      pw1_nxt[a].q    = ph_r[a][31:30];
      pw1_nxt[a].swap = f[29];
      g = f[29] ? (31'd1073741824 - {1'b0, f}) : {1'b0, f};
      p = {31'd0, g} * {31'd0, HalfPiQ30} + (62'd1 << 29);
      pw1_nxt[a].x1 = p[59:30];
    end
  end

  always_comb begin
    for (int a = 0; a < NumAng; a++) begin
      pw_nxt[2][a]     = pw_r[1][a];
      pw_nxt[2][a].x2  = umul_q30(pw_r[1][a].x1, pw_r[1][a].x1);
      pw_nxt[3][a]     = pw_r[2][a];
      pw_nxt[3][a].x3  = umul_q30(pw_r[2][a].x2, pw_r[2][a].x1);
      pw_nxt[3][a].x4  = umul_q30(pw_r[2][a].x2, pw_r[2][a].x2);
      pw_nxt[4][a]     = pw_r[3][a];
      pw_nxt[4][a].x5  = umul_q30(pw_r[3][a].x4, pw_r[3][a].x1);
      pw_nxt[4][a].x6  = umul_q30(pw_r[3][a].x4, pw_r[3][a].x2);
      pw_nxt[4][a].x8  = umul_q30(pw_r[3][a].x4, pw_r[3][a].x4);
      pw_nxt[5][a]     = pw_r[4][a];
      pw_nxt[5][a].x7  = umul_q30(pw_r[4][a].x6, pw_r[4][a].x1);
      pw_nxt[5][a].x9  = umul_q30(pw_r[4][a].x8, pw_r[4][a].x1);
      pw_nxt[5][a].x10 = umul_q30(pw_r[4][a].x8, pw_r[4][a].x2);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NumAng; a++) begin
      if (rdy[1]) pw_r[1][a] <= pw1_nxt[a];
      for (int k = 2; k <= 5; k++) begin
        if (rdy[k]) pw_r[k][a] <= pw_nxt[k][a];
      end
    end
  end

  // stage 6: series terms by reciprocal multiply
  term_t tm_r [NumAng];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NumAng; a++) begin
      if (rdy[6]) begin
        tm_r[a].q    <= pw_r[5][a].q;
        tm_r[a].swap <= pw_r[5][a].swap;
        tm_r[a].x1   <= pw_r[5][a].x1;
        tm_r[a].t2   <= {1'b0, pw_r[5][a].x2[29:1]};
        tm_r[a].t3   <= divc(pw_r[5][a].x3, M6, K6);
        tm_r[a].t4   <= divc(pw_r[5][a].x4, M24, K24);
        tm_r[a].t5   <= divc(pw_r[5][a].x5, M120, K120);
        tm_r[a].t6   <= divc(pw_r[5][a].x6, M720, K720);
        tm_r[a].t7   <= divc(pw_r[5][a].x7, M5040, K5040);
        tm_r[a].t8   <= divc(pw_r[5][a].x8, M40320, K40320);
        tm_r[a].t9   <= divc(pw_r[5][a].x9, M362880, K362880);
        tm_r[a].t10  <= divc(pw_r[5][a].x10, M3628800, K3628800);
      end
    end
  end

  // stage 7: series sums, octant swap, quadrant map
  sc_t sc_r [NumAng];
  sc_t sc_nxt [NumAng];

  always_comb begin
    logic signed [31:0] s;
    logic signed [31:0] c;
    logic signed [31:0] ts;
    logic signed [31:0] tc;
    for (int a = 0; a < NumAng; a++) begin
      s = $signed({2'b0, tm_r[a].x1}) - $signed({2'b0, tm_r[a].t3})
        + $signed({2'b0, tm_r[a].t5}) - $signed({2'b0, tm_r[a].t7})
        + $signed({2'b0, tm_r[a].t9});
      c = OneQ30 - $signed({2'b0, tm_r[a].t2}) + $signed({2'b0, tm_r[a].t4})
        - $signed({2'b0, tm_r[a].t6}) + $signed({2'b0, tm_r[a].t8})
        - $signed({2'b0, tm_r[a].t10});
      ts = tm_r[a].swap ? c : s;
      tc = tm_r[a].swap ? s : c;
      unique case (tm_r[a].q)
        2'd0: begin sc_nxt[a].sn = ts;  sc_nxt[a].cs = tc;  end
        2'd1: begin sc_nxt[a].sn = tc;  sc_nxt[a].cs = -ts; end
        2'd2: begin sc_nxt[a].sn = -ts; sc_nxt[a].cs = -tc; end
        default: begin sc_nxt[a].sn = -tc; sc_nxt[a].cs = ts; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) sc_r <= sc_nxt;
  end

  // stage 8: pairwise products
  logic signed [31:0] sw, cw, sp, cp, sr, cr;
  assign sw = sc_r[0].sn;
  assign cw = sc_r[0].cs;
  assign sp = sc_r[1].sn;
  assign cp = sc_r[1].cs;
  assign sr = sc_r[2].sn;
  assign cr = sc_r[2].cs;

  logic signed [31:0] crcp_r, crsp_r, srcp_r, srsp_r, srcw_r, srsw_r;
  logic signed [31:0] crcw_r, crsw_r, cpsw_r, cpcw_r, nsp_r, sw_r, cw_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      crcp_r <= smul_q30(cr, cp);
      crsp_r <= smul_q30(cr, sp);
      srcp_r <= smul_q30(sr, cp);
      srsp_r <= smul_q30(sr, sp);
      srcw_r <= smul_q30(sr, cw);
      srsw_r <= smul_q30(sr, sw);
      crcw_r <= smul_q30(cr, cw);
      crsw_r <= smul_q30(cr, sw);
      cpsw_r <= smul_q30(cp, sw);
      cpcw_r <= smul_q30(cp, cw);
      nsp_r  <= -sp;
      sw_r   <= sw;
      cw_r   <= cw;
    end
  end

  // stage 9: triple products and sums, Q30
  logic signed [33:0] rq_r [9];

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      rq_r[0] <= 34'(crcp_r);
      rq_r[1] <= 34'(smul_q30(crsp_r, sw_r)) - 34'(srcw_r);
      rq_r[2] <= 34'(smul_q30(crsp_r, cw_r)) + 34'(srsw_r);
      rq_r[3] <= 34'(srcp_r);
      rq_r[4] <= 34'(smul_q30(srsp_r, sw_r)) + 34'(crcw_r);
      rq_r[5] <= 34'(smul_q30(srsp_r, cw_r)) - 34'(crsw_r);
      rq_r[6] <= 34'(nsp_r);
      rq_r[7] <= 34'(cpsw_r);
      rq_r[8] <= 34'(cpcw_r);
    end
  end

  // stage 10: output register
  logic [215:0] rot_r;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      for (int e = 0; e < 9; e++) begin
        rot_r[24*e +: 24] <= to_q22(rq_r[e]);
      end
    end
  end

  assign out_tdata = {tr_r[NumStage-1], rot_r};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] && !rdy[6] |=> vld_r[5])
    else $error("stage 5 dropped a stalled beat");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat not captured");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

### verif/tb_transform_from_pose_unit.sv
// Testbench for transform_from_pose_unit: drives poses, predicts each
// transform with a Q30 sine/cosine series model and checks every beat.
// Depends on rtl/core/tfp_pkg.sv and rtl/core/transform_from_pose_unit.sv.
`timescale 1ns / 1ps
module tb_transform_from_pose_unit;

  typedef struct packed {
    logic [23:0] r;
    logic [23:0] p;
    logic [23:0] w;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  typedef struct packed {
    logic [31:0] tz;
    logic [31:0] ty;
    logic [31:0] tx;
    logic [23:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
  } xform_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [167:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [311:0] out_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  xform_t xform_q[$];

  transform_from_pose_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50ms;
    $display("transform_from_pose_unit verification failed");
    $finish;
  end

  function automatic longint rnd30(longint v);
    longint t;
    t = v + (64'sd1 <<< 29);
    return t >>> 30;
  endfunction

  function automatic void sincos(logic [23:0] ang, output longint sn, output longint cs);
    longint a, prod, f, g, x, x2, x3, x4, x5, x6, x7, x8, x9, x10, s, c, ts, tc;
    logic [31:0] ph;
    logic [1:0] q;
    bit sw;
    a = longint'($signed(ang));
    prod = a * 64'sd683565276 + (64'sd1 <<< 19);
    ph = prod[51:20];
    q = ph[31:30];
    f = longint'(ph[29:0]);
    sw = f >= (64'sd1 <<< 29);
    g = sw ? (64'sd1 <<< 30) - f : f;
    x = rnd30(g * 64'sd1686629713);
    x2 = rnd30(x * x); x3 = rnd30(x2 * x); x4 = rnd30(x2 * x2);
    x5 = rnd30(x4 * x); x6 = rnd30(x4 * x2); x7 = rnd30(x6 * x);
    x8 = rnd30(x4 * x4); x9 = rnd30(x8 * x); x10 = rnd30(x8 * x2);
    s = x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880;
    c = 64'sd1073741824 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320 - x10 / 3628800;
    ts = sw ? c : s;
    tc = sw ? s : c;
    case (q)
      2'd0: begin sn = ts; cs = tc; end
      2'd1: begin sn = tc; cs = -ts; end
      2'd2: begin sn = -ts; cs = -tc; end
      default: begin sn = -tc; cs = ts; end
    endcase
  endfunction

  function automatic logic [23:0] q22(longint v);
    longint t;
    t = (v + 128) >>> 8;
    if (t > 8388607) t = 8388607;
    if (t < -8388608) t = -8388608;
    return t[23:0];
  endfunction

  function automatic xform_t pose_to_xform(pose_t pz);
    longint sw, cw, sp, cp, sr, cr;
    xform_t e;
    sincos(pz.w, sw, cw);
    sincos(pz.p, sp, cp);
    sincos(pz.r, sr, cr);
    e.m00 = q22(rnd30(cr * cp));
    e.m01 = q22(rnd30(rnd30(cr * sp) * sw) - rnd30(sr * cw));
    e.m02 = q22(rnd30(rnd30(cr * sp) * cw) + rnd30(sr * sw));
    e.m10 = q22(rnd30(sr * cp));
    e.m11 = q22(rnd30(rnd30(sr * sp) * sw) + rnd30(cr * cw));
    e.m12 = q22(rnd30(rnd30(sr * sp) * cw) - rnd30(cr * sw));
    e.m20 = q22(-sp);
    e.m21 = q22(rnd30(cp * sw));
    e.m22 = q22(rnd30(cp * cw));
    e.tx = pz.x;
    e.ty = pz.y;
    e.tz = pz.z;
    return e;
  endfunction

  task automatic send_pose(pose_t pz);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= pz;
    xform_q.push_back(pose_to_xform(pz));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic pose_t rand_pose();
    pose_t pz;
    pz = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return pz;
  endfunction

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic chk(string fld, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, fld, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    xform_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (xform_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, got);
        mismatches++;
      end else begin
        want = xform_q.pop_front();
        if (got.m00 !== want.m00) chk("rot_00", 32'(want.m00), 32'(got.m00));
        if (got.m01 !== want.m01) chk("rot_01", 32'(want.m01), 32'(got.m01));
        if (got.m02 !== want.m02) chk("rot_02", 32'(want.m02), 32'(got.m02));
        if (got.m10 !== want.m10) chk("rot_10", 32'(want.m10), 32'(got.m10));
        if (got.m11 !== want.m11) chk("rot_11", 32'(want.m11), 32'(got.m11));
        if (got.m12 !== want.m12) chk("rot_12", 32'(want.m12), 32'(got.m12));
        if (got.m20 !== want.m20) chk("rot_20", 32'(want.m20), 32'(got.m20));
        if (got.m21 !== want.m21) chk("rot_21", 32'(want.m21), 32'(got.m21));
        if (got.m22 !== want.m22) chk("rot_22", 32'(want.m22), 32'(got.m22));
        if (got.tx !== want.tx) chk("trans_x", want.tx, got.tx);
        if (got.ty !== want.ty) chk("trans_y", want.ty, got.ty);
        if (got.tz !== want.tz) chk("trans_z", want.tz, got.tz);
      end
    end
  end

  task automatic drain();
    in_tvalid <= 0;
    while (xform_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [23:0] angs[12];
    pose_t pz;
    angs = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
             24'h192220, 24'h3243F7, 24'h4B65F5, 24'h6487ED, 24'hCDBC09,
             24'h0C9110, 24'h555555};
    send_pose('{r: 0, p: 0, w: 0, z: 32'h7FFFFFFF, y: 32'h80000000, x: 32'hFFFFFFFF});
    send_pose('{r: '1, p: '1, w: '1, z: 0, y: 1, x: 32'h00010000});
    for (int i = 0; i < 12; i++) begin
      pz = rand_pose();
      pz.w = angs[i];
      pz.p = angs[(i + 4) % 12];
      pz.r = angs[(i + 8) % 12];
      send_pose(pz);
    end
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_pose(rand_pose());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 60, 0);
    drain();
    test_random(500, 0, 60);
    test_random(500, 36, 36);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && xform_q.size() == 0) begin
      $display("transform_from_pose_unit verification clean");
    end else begin
      $display("transform_from_pose_unit verification failed");
    end
    $finish;
  end

endmodule

### transform_from_pose_unit.f
rtl/core/tfp_pkg.sv
rtl/core/transform_from_pose_unit.sv
verif/tb_transform_from_pose_unit.sv
